>>> rtl/scc_pkg.sv
`default_nettype none

package scc_pkg;

	// Store geometry
	localparam int MAX_WIDTH  = 64;
	localparam int MAX_HEIGHT = 64;
	localparam int MAX_KERNEL = 7;
	localparam int COEF_BITS  = 16;

	// Fixed field widths of the channels and registers
	localparam int KIND_W     = 2;
	localparam int COORD_W    = 6;
	localparam int PIX_W      = 8;
	localparam int TAP_W      = 3;
	localparam int COEF_IN_W  = 16;
	localparam int DIM_REG_W  = 7;
	localparam int KER_REG_W  = 3;
	localparam int STR_REG_W  = 7;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;

	// Derived widths
	localparam int NUM_LANES  = 3;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int FS_DEPTH   = MAX_WIDTH * MAX_HEIGHT;
	localparam int FS_AW      = $clog2(FS_DEPTH);
	localparam int CS_DEPTH   = MAX_KERNEL * MAX_KERNEL;
	localparam int CS_AW      = $clog2(CS_DEPTH);
	localparam int KIDX_W     = $clog2(MAX_KERNEL);
	localparam int KD_W       = $clog2(MAX_KERNEL + 1);
	localparam int PROD_W     = PIX_W + 1 + COEF_BITS;
	localparam int ACC_W      = PROD_W + $clog2(CS_DEPTH);
	localparam int PIX_MAX    = 255;

	// Item kinds
	localparam logic [KIND_W-1:0] KIND_PIXEL   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_COMPUTE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_COEF    = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STRIDE        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE    = 3'd5;

	typedef logic signed [COEF_BITS-1:0] coef_t;
	typedef logic signed [ACC_W-1:0]     acc_t;

	typedef struct packed {
		logic clear;
		logic tap_ok;
	} lane_ctrl_t;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
		logic             oor;
	} pix_out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_FINISH
	} st_t;

endpackage

`default_nettype wire

>>> rtl/scc_in_if.sv
`default_nettype none

interface scc_in_if;
	logic                                valid;
	logic                                ready;
	logic [scc_pkg::KIND_W-1:0]          kind;
	logic [scc_pkg::COORD_W-1:0]         col;
	logic [scc_pkg::COORD_W-1:0]         row;
	logic [scc_pkg::PIX_W-1:0]           red_or_grey;
	logic [scc_pkg::PIX_W-1:0]           green;
	logic [scc_pkg::PIX_W-1:0]           blue;
	logic [scc_pkg::TAP_W-1:0]           tap_x;
	logic [scc_pkg::TAP_W-1:0]           tap_y;
	logic signed [scc_pkg::COEF_IN_W-1:0] coef_value;

	modport source (
		output valid, kind, col, row, red_or_grey, green, blue, tap_x, tap_y, coef_value,
		input  ready
	);
	modport sink (
		input  valid, kind, col, row, red_or_grey, green, blue, tap_x, tap_y, coef_value,
		output ready
	);
endinterface

`default_nettype wire

>>> rtl/scc_out_if.sv
`default_nettype none

interface scc_out_if;
	logic                      valid;
	logic                      ready;
	logic [scc_pkg::PIX_W-1:0] out_red_or_grey;
	logic [scc_pkg::PIX_W-1:0] out_green;
	logic [scc_pkg::PIX_W-1:0] out_blue;
	logic                      out_of_range;

	modport source (
		output valid, out_red_or_grey, out_green, out_blue, out_of_range,
		input  ready
	);
	modport sink (
		input  valid, out_red_or_grey, out_green, out_blue, out_of_range,
		output ready
	);
endinterface

`default_nettype wire

>>> rtl/scc_mac_lane.sv
`default_nettype none

module scc_mac_lane (
	input  wire logic                       clk,
	input  wire scc_pkg::lane_ctrl_t        ctrl,
	input  wire logic [scc_pkg::PIX_W-1:0]  pix,
	input  wire scc_pkg::coef_t             coef,
	output scc_pkg::acc_t                   acc
);

	logic signed [scc_pkg::PROD_W-1:0] prod_s2;
	scc_pkg::acc_t                     acc_q;

	// Multiply one tap, then fold the registered product into the sum
	always_ff @(posedge clk) begin
		if (ctrl.tap_ok) begin
			prod_s2 <= scc_pkg::PROD_W'($signed({1'b0, pix}) * coef);
		end else begin
			prod_s2 <= '0;
		end
		if (ctrl.clear) begin
			acc_q <= '0;
		end else begin
			acc_q <= acc_q + scc_pkg::ACC_W'(prod_s2);
		end
	end

	assign acc = acc_q;

endmodule

`default_nettype wire

>>> rtl/scc_merge.sv
`default_nettype none

module scc_merge (
	input  wire scc_pkg::acc_t acc [scc_pkg::NUM_LANES],
	input  wire logic          color_mode,
	input  wire logic          oor,
	output scc_pkg::pix_out_t  result
);

	function automatic logic [scc_pkg::PIX_W-1:0] clamp8(input scc_pkg::acc_t s);
		logic [scc_pkg::PIX_W-1:0] r;
		if (s < 0) begin
			r = '0;
		end else if (s > scc_pkg::ACC_W'(scc_pkg::PIX_MAX)) begin
			r = scc_pkg::PIX_W'(scc_pkg::PIX_MAX);
		end else begin
			r = s[scc_pkg::PIX_W-1:0];
		end
		return r;
	endfunction

	always_comb begin
		result = '0;
		if (oor) begin
			result.oor = 1'b1;
		end else begin
			result.red = clamp8(acc[0]);
			// Greyscale reports the red lane only
			if (color_mode) begin
				result.green = clamp8(acc[1]);
				result.blue  = clamp8(acc[2]);
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/strided_2d_convolution_clamp_core.sv
`default_nettype none
// Pixel and coefficient words: stored on accept, no result.
// Compute word: walks kernel_width*kernel_height taps, then drains and loads the result; a centre
//   outside the image skips the walk and goes straight to the result. One compute word at a time;
//   the next word is taken only once the result is loaded, after the one-tap-per-cycle walk.
// Reset (arst_n low, asynchronous): registers to defaults, coefficient store reads zero
//   at once through per-entry valid bits; the frame store is not cleared.

module strided_2d_convolution_clamp_core (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [scc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [scc_pkg::CFG_DATA_W-1:0]     cfg_data,
	scc_in_if.sink                                  in_ch,
	scc_out_if.source                               out_ch
);

	localparam int CX_W         = scc_pkg::COORD_W + scc_pkg::STR_REG_W;
	localparam int POS_W        = ((scc_pkg::COL_W > scc_pkg::ROW_W) ?
	                               scc_pkg::COL_W : scc_pkg::ROW_W) + 2;
	localparam int DRAIN_CYCLES = 2;
	localparam int DRAIN_W      = $clog2(DRAIN_CYCLES);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [scc_pkg::DIM_REG_W-1:0] image_width_q;
	logic [scc_pkg::DIM_REG_W-1:0] image_height_q;
	logic [scc_pkg::KER_REG_W-1:0] kernel_width_q;
	logic [scc_pkg::KER_REG_W-1:0] kernel_height_q;
	logic [scc_pkg::STR_REG_W-1:0] stride_q;
	logic                          color_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q   <= scc_pkg::DIM_REG_W'(64);
			image_height_q  <= scc_pkg::DIM_REG_W'(64);
			kernel_width_q  <= scc_pkg::KER_REG_W'(3);
			kernel_height_q <= scc_pkg::KER_REG_W'(3);
			stride_q        <= scc_pkg::STR_REG_W'(1);
			color_mode_q    <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				scc_pkg::REG_IMAGE_WIDTH:   image_width_q   <= cfg_data[scc_pkg::DIM_REG_W-1:0];
				scc_pkg::REG_IMAGE_HEIGHT:  image_height_q  <= cfg_data[scc_pkg::DIM_REG_W-1:0];
				scc_pkg::REG_KERNEL_WIDTH:  kernel_width_q  <= cfg_data[scc_pkg::KER_REG_W-1:0];
				scc_pkg::REG_KERNEL_HEIGHT: kernel_height_q <= cfg_data[scc_pkg::KER_REG_W-1:0];
				scc_pkg::REG_STRIDE:        stride_q        <= cfg_data[scc_pkg::STR_REG_W-1:0];
				scc_pkg::REG_COLOR_MODE:    color_mode_q    <= cfg_data[0];
				default: ; // drop writes beyond the register list
			endcase
		end
	end

	// Saturate registers to their usable ranges
	logic [scc_pkg::DIM_REG_W-1:0] w_sat, h_sat;
	logic [scc_pkg::KD_W-1:0]      kw_sat, kh_sat;
	logic [scc_pkg::STR_REG_W-1:0] st_sat;

	always_comb begin
		w_sat = (image_width_q == '0) ? scc_pkg::DIM_REG_W'(1) :
		        (image_width_q > scc_pkg::DIM_REG_W'(scc_pkg::MAX_WIDTH)) ?
		        scc_pkg::DIM_REG_W'(scc_pkg::MAX_WIDTH) : image_width_q;
		h_sat = (image_height_q == '0) ? scc_pkg::DIM_REG_W'(1) :
		        (image_height_q > scc_pkg::DIM_REG_W'(scc_pkg::MAX_HEIGHT)) ?
		        scc_pkg::DIM_REG_W'(scc_pkg::MAX_HEIGHT) : image_height_q;
		kw_sat = (kernel_width_q == '0) ? scc_pkg::KD_W'(1) :
		         (scc_pkg::KD_W'(kernel_width_q) > scc_pkg::KD_W'(scc_pkg::MAX_KERNEL)) ?
		         scc_pkg::KD_W'(scc_pkg::MAX_KERNEL) : scc_pkg::KD_W'(kernel_width_q);
		kh_sat = (kernel_height_q == '0) ? scc_pkg::KD_W'(1) :
		         (scc_pkg::KD_W'(kernel_height_q) > scc_pkg::KD_W'(scc_pkg::MAX_KERNEL)) ?
		         scc_pkg::KD_W'(scc_pkg::MAX_KERNEL) : scc_pkg::KD_W'(kernel_height_q);
		st_sat = (stride_q == '0) ? scc_pkg::STR_REG_W'(1) : stride_q;
	end

	// ------------------------------------------------------------------
	// Input decode
	// ------------------------------------------------------------------
	logic            in_acc;
	logic            pix_we, coef_we, start;
	logic [CX_W-1:0] cx_full, cy_full;
	logic            oor_new;

	assign in_acc  = in_ch.valid && in_ch.ready;
	assign pix_we  = in_acc && (in_ch.kind == scc_pkg::KIND_PIXEL) &&
	                 (int'(in_ch.col) < scc_pkg::MAX_WIDTH) &&
	                 (int'(in_ch.row) < scc_pkg::MAX_HEIGHT);
	assign coef_we = in_acc && (in_ch.kind == scc_pkg::KIND_COEF) &&
	                 (int'(in_ch.tap_x) < scc_pkg::MAX_KERNEL) &&
	                 (int'(in_ch.tap_y) < scc_pkg::MAX_KERNEL);
	assign start   = in_acc && (in_ch.kind == scc_pkg::KIND_COMPUTE);

	// Centre of the requested output point in image coordinates
	assign cx_full = CX_W'(in_ch.col) * CX_W'(st_sat);
	assign cy_full = CX_W'(in_ch.row) * CX_W'(st_sat);
	assign oor_new = (cx_full >= CX_W'(w_sat)) || (cy_full >= CX_W'(h_sat));

	// Capture the geometry of one compute word for the whole walk
	logic [scc_pkg::COL_W-1:0]     cx_q;
	logic [scc_pkg::ROW_W-1:0]     cy_q;
	logic                          oor_q;
	logic                          mode_q;
	logic [scc_pkg::DIM_REG_W-1:0] w_q, h_q;
	logic [scc_pkg::KD_W-1:0]      kw_q, kh_q;

	always_ff @(posedge clk) begin
		if (start) begin
			cx_q   <= cx_full[scc_pkg::COL_W-1:0];
			cy_q   <= cy_full[scc_pkg::ROW_W-1:0];
			oor_q  <= oor_new;
			mode_q <= color_mode_q;
			w_q    <= w_sat;
			h_q    <= h_sat;
			kw_q   <= kw_sat;
			kh_q   <= kh_sat;
		end
	end

	// ------------------------------------------------------------------
	// Sequencer: walk taps column by column, rows inner
	// ------------------------------------------------------------------
	scc_pkg::st_t               state_q, state_d;
	logic [scc_pkg::KIDX_W-1:0] x_q, y_q;
	logic [DRAIN_W-1:0]         drain_q;
	logic                       out_valid_q;
	logic                       clear_acc, tap_issue, load_out, in_ready;
	logic                       last_tap;

	assign last_tap = (x_q == scc_pkg::KIDX_W'(kw_q - 1'b1)) &&
	                  (y_q == scc_pkg::KIDX_W'(kh_q - 1'b1));

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		clear_acc = 1'b0;
		tap_issue = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			scc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (start) begin
					clear_acc = 1'b1;
					state_d   = oor_new ? scc_pkg::ST_FINISH : scc_pkg::ST_WALK;
				end
			end
			scc_pkg::ST_WALK: begin
				tap_issue = 1'b1;
				if (last_tap) begin
					state_d = scc_pkg::ST_DRAIN;
				end
			end
			scc_pkg::ST_DRAIN: begin
				if (drain_q == DRAIN_W'(DRAIN_CYCLES - 1)) begin
					state_d = scc_pkg::ST_FINISH;
				end
			end
			scc_pkg::ST_FINISH: begin
				// Hold until the output register is free
				if (!out_valid_q || out_ch.ready) begin
					load_out = 1'b1;
					state_d  = scc_pkg::ST_IDLE;
				end
			end
			default: state_d = scc_pkg::ST_IDLE;
		endcase
	end

	assign in_ch.ready = in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= scc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q     <= '0;
			y_q     <= '0;
			drain_q <= '0;
		end else begin
			if (start) begin
				x_q     <= '0;
				y_q     <= '0;
				drain_q <= '0;
			end else if (tap_issue) begin
				// Advance row inside column, then step the column
				if (y_q == scc_pkg::KIDX_W'(kh_q - 1'b1)) begin
					y_q <= '0;
					x_q <= x_q + 1'b1;
				end else begin
					y_q <= y_q + 1'b1;
				end
			end else if (state_q == scc_pkg::ST_DRAIN) begin
				drain_q <= drain_q + 1'b1;
			end
		end
	end

	// Image position of the current tap; skip taps that leave the image
	logic signed [POS_W-1:0]  px_s, py_s;
	logic                     tap_ok;
	logic [scc_pkg::FS_AW-1:0] fs_raddr, fs_waddr;
	logic [scc_pkg::CS_AW-1:0] cs_raddr, cs_waddr;

	always_comb begin
		px_s = $signed(POS_W'(cx_q)) - $signed(POS_W'(kw_q >> 1)) + $signed(POS_W'(x_q));
		py_s = $signed(POS_W'(cy_q)) - $signed(POS_W'(kh_q >> 1)) + $signed(POS_W'(y_q));
		tap_ok = tap_issue &&
		         !px_s[POS_W-1] && (px_s < $signed(POS_W'(w_q))) &&
		         !py_s[POS_W-1] && (py_s < $signed(POS_W'(h_q)));
		fs_raddr = scc_pkg::FS_AW'(py_s[scc_pkg::ROW_W-1:0]) *
		           scc_pkg::FS_AW'(scc_pkg::MAX_WIDTH) +
		           scc_pkg::FS_AW'(px_s[scc_pkg::COL_W-1:0]);
		cs_raddr = scc_pkg::CS_AW'(y_q) * scc_pkg::CS_AW'(scc_pkg::MAX_KERNEL) +
		           scc_pkg::CS_AW'(x_q);
		fs_waddr = scc_pkg::FS_AW'(in_ch.row) * scc_pkg::FS_AW'(scc_pkg::MAX_WIDTH) +
		           scc_pkg::FS_AW'(in_ch.col);
		cs_waddr = scc_pkg::CS_AW'(in_ch.tap_y) * scc_pkg::CS_AW'(scc_pkg::MAX_KERNEL) +
		           scc_pkg::CS_AW'(in_ch.tap_x);
	end

	// ------------------------------------------------------------------
	// Frame and coefficient stores, registered read
	// ------------------------------------------------------------------
	logic [scc_pkg::NUM_LANES*scc_pkg::PIX_W-1:0] frame_mem [scc_pkg::FS_DEPTH];
	scc_pkg::coef_t                               coef_mem  [scc_pkg::CS_DEPTH];
	logic [scc_pkg::CS_DEPTH-1:0]                 coef_valid_q;
	logic [scc_pkg::NUM_LANES*scc_pkg::PIX_W-1:0] fs_rd_s1;
	scc_pkg::coef_t                               cs_rd_s1;
	logic                                         cs_vld_s1;
	logic                                         tap_ok_s1;
	scc_pkg::coef_t                               coef_eff;

	always_ff @(posedge clk) begin
		if (pix_we) begin
			frame_mem[fs_waddr] <= {in_ch.red_or_grey, in_ch.green, in_ch.blue};
		end
		fs_rd_s1 <= frame_mem[fs_raddr];
	end

	always_ff @(posedge clk) begin
		if (coef_we) begin
			coef_mem[cs_waddr] <= scc_pkg::COEF_BITS'(in_ch.coef_value);
		end
		cs_rd_s1 <= coef_mem[cs_raddr];
	end

	// Entries never written since reset read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_valid_q <= '0;
			cs_vld_s1    <= 1'b0;
			tap_ok_s1    <= 1'b0;
		end else begin
			if (coef_we) begin
				coef_valid_q[cs_waddr] <= 1'b1;
			end
			cs_vld_s1 <= coef_valid_q[cs_raddr];
			tap_ok_s1 <= tap_ok;
		end
	end

	assign coef_eff = cs_vld_s1 ? cs_rd_s1 : '0;

	// ------------------------------------------------------------------
	// Channel lanes: red, green, blue side by side
	// ------------------------------------------------------------------
	scc_pkg::lane_ctrl_t lane_ctrl;
	scc_pkg::acc_t       lane_acc [scc_pkg::NUM_LANES];

	assign lane_ctrl.clear  = clear_acc;
	assign lane_ctrl.tap_ok = tap_ok_s1;

	for (genvar i = 0; i < scc_pkg::NUM_LANES; i++) begin : g_lane
		scc_mac_lane u_lane (
			.clk  (clk),
			.ctrl (lane_ctrl),
			.pix  (fs_rd_s1[scc_pkg::PIX_W*(scc_pkg::NUM_LANES-i)-1 -: scc_pkg::PIX_W]),
			.coef (coef_eff),
			.acc  (lane_acc[i])
		);
	end

	// Clamp and combine the lane sums
	scc_pkg::pix_out_t merged;

	scc_merge u_merge (
		.acc        (lane_acc),
		.color_mode (mode_q),
		.oor        (oor_q),
		.result     (merged)
	);

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	scc_pkg::pix_out_t out_pix_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_pix_q <= merged;
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.out_red_or_grey = out_pix_q.red;
	assign out_ch.out_green       = out_pix_q.green;
	assign out_ch.out_blue        = out_pix_q.blue;
	assign out_ch.out_of_range    = out_pix_q.oor;

`ifndef NO_ASSERTIONS
	// An off-image centre reports all channels zero
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.out_of_range |->
			(out_ch.out_red_or_grey == '0) && (out_ch.out_green == '0) &&
			(out_ch.out_blue == '0))
		else $error("off-image result carries nonzero channels");

	// Tap counters stay inside the captured kernel during the walk
	a_tap_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == scc_pkg::ST_WALK |->
			(scc_pkg::KD_W'(x_q) < kw_q) && (scc_pkg::KD_W'(y_q) < kh_q))
		else $error("tap counter outside kernel");

	// A result appears only after the finishing step
	a_out_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == scc_pkg::ST_FINISH))
		else $error("result raised outside finish step");
`endif

endmodule

`default_nettype wire
